FILE: hw/rtl/msp_pkg.sv
// Shared constants and types of the matrix saddle point finder.
package msp_pkg;

  localparam int MSP_MAX_ROWS     = 8;
  localparam int MSP_MAX_COLUMNS  = 8;
  localparam int MSP_VALUE_BITS   = 32;
  localparam int MSP_QUEUE_DEPTH  = 4;
  localparam int MSP_ADDR_BITS    = 3;
  localparam int MSP_DIM_BITS     = 4;
  localparam int MSP_ELEMENT_BITS = 32;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } msp_reg_t;

  typedef struct packed {
    logic first_col;
    logic first_row;
    logic final_elem;
  } msp_flags_t;

endpackage

FILE: hw/rtl/matrix_saddle_point_finder_unit.sv
// Top level of the matrix saddle point finder with its register port.
//
// Matrix elements are taken one beat per clock cycle in row-major order while the queue
// is not full, and the element store, the running row minima and the column maxima are
// updated. After the final element of a matrix the back end scans the stored matrix
// through its single-read-port memories, one entry per cycle while result beats are not
// stalled, and emits every saddle point with its row and column counted from one, marking
// the last beat; a matrix without a saddle point gives one beat with point_valid low.
// During the scan the front end keeps taking elements of the next matrix into a
// four-entry queue and stalls once it is full. The stores are not cleared after reset,
// so no clearing pass is needed. A write to either dimension register restarts loading
// at the first row and column.
module matrix_saddle_point_finder_unit
  import msp_pkg::*;
#(
  parameter int MAX_ROWS    = MSP_MAX_ROWS,
  parameter int MAX_COLUMNS = MSP_MAX_COLUMNS,
  parameter int VALUE_BITS  = MSP_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [MSP_ADDR_BITS-1:0]           paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               element_valid,
  input  logic signed [MSP_ELEMENT_BITS-1:0] element_value,
  output logic                               element_stall,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [MSP_ELEMENT_BITS-1:0] point_value,
  output logic [MSP_DIM_BITS-1:0]            point_row,
  output logic [MSP_DIM_BITS-1:0]            point_column,
  output logic                               point_valid,
  output logic                               last_of_run
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int QW  = VALUE_BITS + RIW + CIW + $bits(msp_flags_t);

  logic [MSP_DIM_BITS-1:0] row_count;
  logic [MSP_DIM_BITS-1:0] column_count;
  logic                    cfg_write;
  msp_reg_t                cfg_index;
  logic [RNW-1:0]          rows;
  logic [CNW-1:0]          cols;

  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  logic [QW-1:0]           q_push_data;
  logic [QW-1:0]           q_pop_data;

  logic [VALUE_BITS-1:0]   f_value;
  logic [RIW-1:0]          f_row;
  logic [CIW-1:0]          f_col;
  msp_flags_t              f_flags;
  logic [VALUE_BITS-1:0]   b_value;
  logic [RIW-1:0]          b_row;
  logic [CIW-1:0]          b_col;
  msp_flags_t              b_flags;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = msp_reg_t'(paddr[2]);

  always_comb begin
    unique case (cfg_index)
      REG_ROW_COUNT:    prdata = {{(32 - MSP_DIM_BITS){1'b0}}, row_count};
      REG_COLUMN_COUNT: prdata = {{(32 - MSP_DIM_BITS){1'b0}}, column_count};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= MSP_DIM_BITS'(8);
      column_count <= MSP_DIM_BITS'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= pwdata[MSP_DIM_BITS-1:0];
        REG_COLUMN_COUNT: column_count <= pwdata[MSP_DIM_BITS-1:0];
        default:          row_count    <= row_count;
      endcase
    end
  end

  // Dimensions of zero count as one, and values above the maximum as the maximum.
  always_comb begin
    if (row_count == '0) begin
      rows = RNW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(row_count);
    end
    if (column_count == '0) begin
      cols = CNW'(1);
    end else if (int'(column_count) > MAX_COLUMNS) begin
      cols = CNW'(MAX_COLUMNS);
    end else begin
      cols = CNW'(column_count);
    end
  end

  msp_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_write),
    .rows          (rows),
    .cols          (cols),
    .element_valid (element_valid),
    .element_value (element_value),
    .element_stall (element_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_value       (f_value),
    .q_row         (f_row),
    .q_col         (f_col),
    .q_flags       (f_flags)
  );

  assign q_push_data = {f_value, f_row, f_col, f_flags};
  assign {b_value, b_row, b_col, b_flags} = q_pop_data;

  msp_queue #(
    .WIDTH (QW),
    .DEPTH (MSP_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  msp_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rows         (rows),
    .cols         (cols),
    .q_valid      (!q_empty),
    .q_value      (b_value),
    .q_row        (b_row),
    .q_col        (b_col),
    .q_flags      (b_flags),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .point_value  (point_value),
    .point_row    (point_row),
    .point_column (point_column),
    .point_valid  (point_valid),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: hw/rtl/msp_queue.sv
// Small first-in first-out queue between the front end and the back end.
module msp_queue
  import msp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MSP_QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/msp_front.sv
// Front end: takes element beats, tracks the load position and classifies each element.
module msp_front
  import msp_pkg::*;
#(
  parameter int MAX_ROWS    = MSP_MAX_ROWS,
  parameter int MAX_COLUMNS = MSP_MAX_COLUMNS,
  parameter int VALUE_BITS  = MSP_VALUE_BITS,
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int RNW = $clog2(MAX_ROWS + 1),
  localparam int CNW = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic [RNW-1:0]                     rows,
  input  logic [CNW-1:0]                     cols,
  input  logic                               element_valid,
  input  logic signed [MSP_ELEMENT_BITS-1:0] element_value,
  output logic                               element_stall,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [VALUE_BITS-1:0]              q_value,
  output logic [RIW-1:0]                     q_row,
  output logic [CIW-1:0]                     q_col,
  output msp_flags_t                         q_flags
);

  logic [RIW-1:0] load_row;
  logic [CIW-1:0] load_column;
  logic           col_last;
  logic           row_last;

  assign element_stall = q_full;
  assign q_push        = element_valid && !q_full;

  assign col_last = ((CNW'(load_column) + CNW'(1)) == cols);
  assign row_last = ((RNW'(load_row) + RNW'(1)) == rows);

  assign q_value            = VALUE_BITS'(element_value);
  assign q_row              = load_row;
  assign q_col              = load_column;
  assign q_flags.first_col  = (load_column == '0);
  assign q_flags.first_row  = (load_row == '0);
  assign q_flags.final_elem = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_row    <= '0;
      load_column <= '0;
    end else if (q_push) begin
      if (col_last) begin
        load_column <= '0;
        load_row    <= row_last ? '0 : load_row + RIW'(1);
      end else begin
        load_column <= load_column + CIW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/msp_back.sv
// Back end: updates the element store and trackers, then scans for saddle points.
module msp_back
  import msp_pkg::*;
#(
  parameter int MAX_ROWS    = MSP_MAX_ROWS,
  parameter int MAX_COLUMNS = MSP_MAX_COLUMNS,
  parameter int VALUE_BITS  = MSP_VALUE_BITS,
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int RNW   = $clog2(MAX_ROWS + 1),
  localparam int CNW   = $clog2(MAX_COLUMNS + 1),
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [RNW-1:0]                     rows,
  input  logic [CNW-1:0]                     cols,
  input  logic                               q_valid,
  input  logic [VALUE_BITS-1:0]              q_value,
  input  logic [RIW-1:0]                     q_row,
  input  logic [CIW-1:0]                     q_col,
  input  msp_flags_t                         q_flags,
  output logic                               q_pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [MSP_ELEMENT_BITS-1:0] point_value,
  output logic [MSP_DIM_BITS-1:0]            point_row,
  output logic [MSP_DIM_BITS-1:0]            point_column,
  output logic                               point_valid,
  output logic                               last_of_run
);

  typedef enum logic [1:0] {
    LOAD,
    SCAN,
    FLUSH
  } state_t;

  function automatic logic [AW-1:0] elem_addr(input logic [RIW-1:0] r,
                                              input logic [CIW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLUMNS)) + AW'(c);
  endfunction

  state_t state;

  logic [VALUE_BITS-1:0] element_mem [DEPTH];
  logic [VALUE_BITS-1:0] rowmin_mem  [MAX_ROWS];
  logic [VALUE_BITS-1:0] colmax_mem  [MAX_COLUMNS];

  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_value;
  logic [RIW-1:0]        s1_row;
  logic [CIW-1:0]        s1_col;
  msp_flags_t            s1_flags;
  logic                  fwd_hit;
  logic [VALUE_BITS-1:0] fwd_value;
  logic [VALUE_BITS-1:0] rowmin_run;

  logic [VALUE_BITS-1:0] elem_rd;
  logic [VALUE_BITS-1:0] rowmin_rd;
  logic [VALUE_BITS-1:0] colmax_rd;

  logic [RIW-1:0]        scan_row;
  logic [CIW-1:0]        scan_col;
  logic                  issued_all;
  logic                  cmp_valid;
  logic [RIW-1:0]        cmp_row;
  logic [CIW-1:0]        cmp_col;
  logic                  cmp_end;
  logic                  pend_valid;
  logic [VALUE_BITS-1:0] pend_value;
  logic [RIW-1:0]        pend_row;
  logic [CIW-1:0]        pend_col;

  logic [VALUE_BITS-1:0] colmax_old;
  logic [VALUE_BITS-1:0] rowmin_new;
  logic [VALUE_BITS-1:0] colmax_new;
  logic                  out_free;
  logic                  cmp_match;
  logic                  cmp_adv;
  logic                  issue;
  logic                  result_load;
  logic                  scan_col_last;
  logic                  scan_row_last;
  logic [CIW-1:0]        col_rd_addr;
  logic                  col_rd_en;

  // A column maximum written in the cycle its next reader is fetched is forwarded.
  assign colmax_old = fwd_hit ? fwd_value : colmax_rd;
  assign rowmin_new = (s1_flags.first_col || ($signed(s1_value) < $signed(rowmin_run))) ?
                      s1_value : rowmin_run;
  assign colmax_new = (s1_flags.first_row || ($signed(colmax_old) < $signed(s1_value))) ?
                      s1_value : colmax_old;

  assign q_pop = (state == LOAD) && q_valid && !(s1_valid && s1_flags.final_elem);

  assign out_free  = !result_valid || !result_stall;
  assign cmp_match = (elem_rd == rowmin_rd) && (elem_rd == colmax_rd);
  assign cmp_adv   = cmp_valid && (!cmp_match || !pend_valid || out_free);
  assign issue     = (state == SCAN) && !issued_all && (!cmp_valid || cmp_adv);

  assign result_load = ((state == SCAN) && cmp_adv && cmp_match && pend_valid) ||
                       ((state == FLUSH) && out_free);

  assign scan_col_last = ((CNW'(scan_col) + CNW'(1)) == cols);
  assign scan_row_last = ((RNW'(scan_row) + RNW'(1)) == rows);

  assign col_rd_addr = (state == LOAD) ? q_col : scan_col;
  assign col_rd_en   = q_pop || issue;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      element_mem[elem_addr(s1_row, s1_col)] <= s1_value;
    end
    if (issue) begin
      elem_rd <= element_mem[elem_addr(scan_row, scan_col)];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      rowmin_mem[s1_row] <= rowmin_new;
    end
    if (issue) begin
      rowmin_rd <= rowmin_mem[scan_row];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      colmax_mem[s1_col] <= colmax_new;
    end
    if (col_rd_en) begin
      colmax_rd <= colmax_mem[col_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      s1_valid     <= 1'b0;
      cmp_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      issued_all   <= 1'b0;
      scan_row     <= '0;
      scan_col     <= '0;
    end else begin
      s1_valid <= q_pop;
      if (s1_valid) begin
        rowmin_run <= rowmin_new;
      end
      if (q_pop) begin
        s1_value  <= q_value;
        s1_row    <= q_row;
        s1_col    <= q_col;
        s1_flags  <= q_flags;
        fwd_hit   <= s1_valid && (s1_col == q_col);
        fwd_value <= colmax_new;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        LOAD: begin
          if (s1_valid && s1_flags.final_elem) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (issue) begin
            cmp_row <= scan_row;
            cmp_col <= scan_col;
            cmp_end <= scan_row_last && scan_col_last;
            if (scan_col_last) begin
              scan_col <= '0;
              if (scan_row_last) begin
                scan_row   <= '0;
                issued_all <= 1'b1;
              end else begin
                scan_row <= scan_row + RIW'(1);
              end
            end else begin
              scan_col <= scan_col + CIW'(1);
            end
          end
          if (cmp_adv) begin
            if (cmp_match) begin
              if (pend_valid) begin
                point_value  <= MSP_ELEMENT_BITS'($signed(pend_value));
                point_row    <= MSP_DIM_BITS'(pend_row) + MSP_DIM_BITS'(1);
                point_column <= MSP_DIM_BITS'(pend_col) + MSP_DIM_BITS'(1);
                point_valid  <= 1'b1;
                last_of_run  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_value <= elem_rd;
              pend_row   <= cmp_row;
              pend_col   <= cmp_col;
            end
            if (cmp_end) begin
              state <= FLUSH;
            end
          end
          cmp_valid <= issue || (cmp_valid && !cmp_adv);
        end
        FLUSH: begin
          if (out_free) begin
            last_of_run  <= 1'b1;
            if (pend_valid) begin
              point_value  <= MSP_ELEMENT_BITS'($signed(pend_value));
              point_row    <= MSP_DIM_BITS'(pend_row) + MSP_DIM_BITS'(1);
              point_column <= MSP_DIM_BITS'(pend_col) + MSP_DIM_BITS'(1);
              point_valid  <= 1'b1;
            end else begin
              point_value  <= '0;
              point_row    <= '0;
              point_column <= '0;
              point_valid  <= 1'b0;
            end
            pend_valid <= 1'b0;
            issued_all <= 1'b0;
            state      <= LOAD;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule
